@@ rtl/core/sector_cache_clock_replacement_defines.svh @@
// assertion macros for the sector cache tag and replacement engine
`ifndef SECTOR_CACHE_CLOCK_REPLACEMENT_DEFINES_SVH
`define SECTOR_CACHE_CLOCK_REPLACEMENT_DEFINES_SVH

// plain property, sampled on clk_i, off during reset
`define SCCR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on the same edge
`define SCCR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication checked on the next edge
`define SCCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sccr_pkg.sv @@
// types and constants of the sector cache tag and replacement engine
`default_nettype none

package sccr_pkg;

  localparam int unsigned SectorW    = 32;
  localparam int unsigned SlotW      = 6;
  localparam int unsigned MaxResults = 64;
  localparam int unsigned FlushCntW  = 7;

  localparam logic [1:0] ModeRead  = 2'd0;
  localparam logic [1:0] ModeWrite = 2'd1;
  localparam logic [1:0] ModeFlush = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [SectorW-1:0] sector;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [SlotW-1:0]   slot;
    logic               writeback;
    logic [SectorW-1:0] writeback_sector;
    logic               fetch;
    logic               last;
  } rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/sector_cache_clock_replacement.sv @@
// sector cache tag and clock replacement engine, top level
// usage:
//   in channel (in_valid_i / in_ready_o / in_req_i) takes one request at a time:
//   read, write or flush; any other mode is taken and dropped without a result.
//   out channel (out_valid_o / out_ready_i / out_rsp_o) returns one result per
//   read or write and one per dirty slot, up to MaxResults, for a flush, last
//   set on the final one; a flush with no dirty slot returns nothing.
// timing:
//   tags live in one synchronous memory read once per cycle, so the lookup
//   walks the slots in order and stops at a hit; a miss finishes the lookup,
//   runs the clock sweep, whose last step reads the old tag, and then installs
//   the new sector. a flush walks the slots in order, with an extra read step
//   for each dirty slot and a closing step. in_ready_o is high only between
//   requests; a result still waiting in the output register does not hold off
//   the next request.
// reset: all valid, dirty and accessed marks and the clock hand clear at once;
//   the tag memory is not cleared and its data is only used behind a valid or dirty mark.
// stalls: when a result is due but the output register is full and out_ready_i
//   is low, the engine waits with its state frozen until the register is free.
`default_nettype none
`include "sector_cache_clock_replacement_defines.svh"

module sector_cache_clock_replacement #(
  parameter int unsigned ENTRIES = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire sccr_pkg::req_t in_req_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output sccr_pkg::rsp_t    out_rsp_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned CntW = IdxW + 1;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SScan  = 3'd1;
  localparam logic [2:0] SHit   = 3'd2;
  localparam logic [2:0] SSweep = 3'd3;
  localparam logic [2:0] SVict  = 3'd4;
  localparam logic [2:0] SFScan = 3'd5;
  localparam logic [2:0] SFRead = 3'd6;
  localparam logic [2:0] SFEnd  = 3'd7;

  logic [2:0] state_q, state_d;

  logic [1:0]                   mode_q, mode_d;
  logic [sccr_pkg::SectorW-1:0] sector_q, sector_d;

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [ENTRIES-1:0] dirty_q, dirty_d;
  logic [ENTRIES-1:0] acc_q, acc_d;
  logic [IdxW-1:0]    hand_q, hand_d;

  logic [CntW-1:0] scan_q, scan_d;
  logic            cmp_valid_q, cmp_valid_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0] vict_q, vict_d;

  logic [sccr_pkg::FlushCntW-1:0] fcnt_q, fcnt_d;
  logic                           held_valid_q, held_valid_d;
  logic [IdxW-1:0]                held_slot_q, held_slot_d;
  logic [sccr_pkg::SectorW-1:0]   held_tag_q, held_tag_d;

  logic           out_valid_q, out_valid_d;
  sccr_pkg::rsp_t out_q, rsp_d;
  logic           emit;
  logic           out_free;

  // tag memory
  logic [sccr_pkg::SectorW-1:0] tag_mem [ENTRIES];
  logic                         mem_re, mem_we;
  logic [IdxW-1:0]              mem_ra;
  logic [sccr_pkg::SectorW-1:0] rdata_q;

  logic            scan_more;
  logic            scan_hit;
  logic            flush_done;
  logic [IdxW-1:0] hand_next;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[vict_q] <= sector_q;
    end
    if (mem_re) begin
      rdata_q <= tag_mem[mem_ra];
    end
  end

  function automatic logic [sccr_pkg::SlotW-1:0] to_slot(input logic [IdxW-1:0] idx);
    logic [IdxW+sccr_pkg::SlotW-1:0] ext;
    ext = {{sccr_pkg::SlotW{1'b0}}, idx};
    return ext[sccr_pkg::SlotW-1:0];
  endfunction

  assign out_free   = !out_valid_q || out_ready_i;
  assign scan_more  = scan_q < CntW'(ENTRIES);
  assign scan_hit   = cmp_valid_q && valid_q[cmp_idx_q] && (rdata_q == sector_q);
  assign flush_done = !scan_more || (fcnt_q == sccr_pkg::FlushCntW'(sccr_pkg::MaxResults));
  assign hand_next  = (hand_q == IdxW'(ENTRIES - 1)) ? '0 : hand_q + 1'b1;

  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    sector_d     = sector_q;
    valid_d      = valid_q;
    dirty_d      = dirty_q;
    acc_d        = acc_q;
    hand_d       = hand_q;
    scan_d       = scan_q;
    cmp_valid_d  = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    vict_d       = vict_q;
    fcnt_d       = fcnt_q;
    held_valid_d = held_valid_q;
    held_slot_d  = held_slot_q;
    held_tag_d   = held_tag_q;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    mem_ra       = scan_q[IdxW-1:0];
    emit         = 1'b0;
    rsp_d        = '0;

    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          mode_d       = in_req_i.mode;
          sector_d     = in_req_i.sector;
          scan_d       = '0;
          fcnt_d       = '0;
          held_valid_d = 1'b0;
          if (in_req_i.mode == sccr_pkg::ModeRead || in_req_i.mode == sccr_pkg::ModeWrite) begin
            state_d = SScan;
          end else if (in_req_i.mode == sccr_pkg::ModeFlush) begin
            state_d = SFScan;
          end
        end
      end

      // one tag read per cycle, each read compared in the cycle after it
      SScan: begin
        if (scan_hit) begin
          vict_d  = cmp_idx_q;
          state_d = SHit;
        end else if (scan_more) begin
          mem_re      = 1'b1;
          cmp_valid_d = 1'b1;
          cmp_idx_d   = scan_q[IdxW-1:0];
          scan_d      = scan_q + 1'b1;
        end else if (!cmp_valid_q) begin
          state_d = SSweep;
        end
      end

      SHit: begin
        if (out_free) begin
          emit           = 1'b1;
          rsp_d.hit      = 1'b1;
          rsp_d.slot     = to_slot(vict_q);
          rsp_d.last     = 1'b1;
          acc_d[vict_q]  = 1'b1;
          if (mode_q == sccr_pkg::ModeWrite) begin
            dirty_d[vict_q] = 1'b1;
          end
          state_d = SIdle;
        end
      end

      // second chance: clear accessed marks until one is found clear
      SSweep: begin
        hand_d = hand_next;
        if (acc_q[hand_q]) begin
          acc_d[hand_q] = 1'b0;
        end else begin
          vict_d  = hand_q;
          mem_re  = 1'b1;
          mem_ra  = hand_q;
          state_d = SVict;
        end
      end

      // old tag is in rdata_q; install the new sector
      SVict: begin
        if (out_free) begin
          emit            = 1'b1;
          rsp_d.slot      = to_slot(vict_q);
          rsp_d.writeback = valid_q[vict_q] && dirty_q[vict_q];
          rsp_d.writeback_sector = (valid_q[vict_q] && dirty_q[vict_q]) ? rdata_q : '0;
          rsp_d.fetch     = (mode_q == sccr_pkg::ModeRead);
          rsp_d.last      = 1'b1;
          mem_we          = 1'b1;
          valid_d[vict_q] = 1'b1;
          dirty_d[vict_q] = (mode_q == sccr_pkg::ModeWrite);
          acc_d[vict_q]   = 1'b1;
          state_d         = SIdle;
        end
      end

      SFScan: begin
        if (flush_done) begin
          state_d = SFEnd;
        end else if (dirty_q[scan_q[IdxW-1:0]]) begin
          mem_re  = 1'b1;
          state_d = SFRead;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      // one dirty slot is held back so the final one can carry last
      SFRead: begin
        if (!held_valid_q || out_free) begin
          if (held_valid_q) begin
            emit                   = 1'b1;
            rsp_d.slot             = to_slot(held_slot_q);
            rsp_d.writeback        = 1'b1;
            rsp_d.writeback_sector = held_tag_q;
          end
          held_valid_d                  = 1'b1;
          held_slot_d                   = scan_q[IdxW-1:0];
          held_tag_d                    = rdata_q;
          dirty_d[scan_q[IdxW-1:0]]     = 1'b0;
          fcnt_d                        = fcnt_q + 1'b1;
          scan_d                        = scan_q + 1'b1;
          state_d                       = SFScan;
        end
      end

      SFEnd: begin
        if (!held_valid_q) begin
          state_d = SIdle;
        end else if (out_free) begin
          emit                   = 1'b1;
          rsp_d.slot             = to_slot(held_slot_q);
          rsp_d.writeback        = 1'b1;
          rsp_d.writeback_sector = held_tag_q;
          rsp_d.last             = 1'b1;
          held_valid_d           = 1'b0;
          state_d                = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign out_valid_d = emit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      valid_q      <= '0;
      dirty_q      <= '0;
      acc_q        <= '0;
      hand_q       <= '0;
      cmp_valid_q  <= 1'b0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      dirty_q      <= dirty_d;
      acc_q        <= acc_d;
      hand_q       <= hand_d;
      cmp_valid_q  <= cmp_valid_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    sector_q    <= sector_d;
    scan_q      <= scan_d;
    cmp_idx_q   <= cmp_idx_d;
    vict_q      <= vict_d;
    fcnt_q      <= fcnt_d;
    held_slot_q <= held_slot_d;
    held_tag_q  <= held_tag_d;
    if (emit) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `SCCR_ASSERT_IMPL(a_emit_free, emit, !out_valid_q || out_ready_i, "result overwrites pending result")
  `SCCR_ASSERT_IMPL(a_hit_clean, out_valid_o && out_rsp_o.hit, !out_rsp_o.writeback && !out_rsp_o.fetch, "hit result with writeback or fetch")
  `SCCR_ASSERT_NEXT(a_install, state_q == SVict && emit, valid_q[vict_q] && acc_q[vict_q], "victim not installed")
  `SCCR_ASSERT_NEXT(a_flush_clean, state_q == SFRead && state_d == SFScan, !dirty_q[held_slot_q], "flushed slot still dirty")

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// self-checking testbench for the sector cache tag and clock replacement engine
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Entries       = 64;
  localparam int unsigned HotSize       = 96;
  localparam int unsigned DrainCycles   = 4 * Entries + 20;
  localparam int unsigned TimeoutCycles = 2_000_000;
  localparam int unsigned LongHold      = 400;
  localparam logic [1:0]  ModeUnused    = 2'd3;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic out_ready = 1'b0;
  sccr_pkg::req_t in_req = '0;
  logic in_ready_o;
  logic out_valid_o;
  sccr_pkg::rsp_t out_rsp_o;

  // predictor state
  logic [sccr_pkg::SectorW-1:0] line_tag [Entries];
  logic                         line_valid [Entries];
  logic                         line_dirty [Entries];
  logic                         line_ref [Entries];
  int unsigned                  hand_pos;

  sccr_pkg::rsp_t               expected_rsp_q [$];
  logic [sccr_pkg::SectorW-1:0] hot_sector [HotSize];
  int unsigned                  n_fail           = 0;
  int unsigned                  cycle_cnt        = 0;
  int unsigned                  long_hold_cycles = 0;
  bit                           send_idle_en     = 1'b1;
  bit                           rsp_idle_en      = 1'b1;

  sector_cache_clock_replacement #(
    .ENTRIES(Entries)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // expected results of one accepted request, state updated as the engine does
  function automatic void predict_lookup(input sccr_pkg::req_t r);
    sccr_pkg::rsp_t x;
    int             found;
    int unsigned    victim;
    int unsigned    n;
    found = -1;
    n     = 0;
    x     = '0;
    case (r.mode)
      sccr_pkg::ModeFlush: begin
        for (int unsigned i = 0; i < Entries && n < sccr_pkg::MaxResults; i++) begin
          if (line_dirty[i]) begin
            x = '0;
            x.slot             = sccr_pkg::SlotW'(i);
            x.writeback        = 1'b1;
            x.writeback_sector = line_tag[i];
            expected_rsp_q.push_back(x);
            line_dirty[i] = 1'b0;
            n++;
          end
        end
        if (n != 0) expected_rsp_q[expected_rsp_q.size()-1].last = 1'b1;
      end
      sccr_pkg::ModeRead, sccr_pkg::ModeWrite: begin
        for (int i = 0; i < Entries; i++) begin
          if (found < 0 && line_valid[i] && line_tag[i] == r.sector) found = i;
        end
        x.last = 1'b1;
        if (found >= 0) begin
          line_ref[found] = 1'b1;
          if (r.mode == sccr_pkg::ModeWrite) line_dirty[found] = 1'b1;
          x.hit  = 1'b1;
          x.slot = sccr_pkg::SlotW'(found);
        end else begin
          // second-chance sweep
          while (line_ref[hand_pos]) begin
            line_ref[hand_pos] = 1'b0;
            hand_pos = (hand_pos + 1) % Entries;
          end
          victim   = hand_pos;
          hand_pos = (hand_pos + 1) % Entries;
          x.slot   = sccr_pkg::SlotW'(victim);
          if (line_valid[victim] && line_dirty[victim]) begin
            x.writeback        = 1'b1;
            x.writeback_sector = line_tag[victim];
          end
          x.fetch            = (r.mode == sccr_pkg::ModeRead);
          line_tag[victim]   = r.sector;
          line_valid[victim] = 1'b1;
          line_dirty[victim] = (r.mode == sccr_pkg::ModeWrite);
          line_ref[victim]   = 1'b1;
        end
        expected_rsp_q.push_back(x);
      end
      default: ;
    endcase
  endfunction

  // mostly a hot working set so that hits, sweeps and dirty evictions all occur
  function automatic sccr_pkg::req_t rand_req();
    sccr_pkg::req_t r;
    int unsigned    pick;
    pick     = $urandom_range(0, 99);
    r.sector = hot_sector[$urandom_range(0, HotSize-1)];
    if (pick < 50) begin
      r.mode = sccr_pkg::ModeRead;
    end else if (pick < 85) begin
      r.mode = sccr_pkg::ModeWrite;
    end else if (pick < 93) begin
      r.mode   = pick[0] ? sccr_pkg::ModeRead : sccr_pkg::ModeWrite;
      r.sector = $urandom();
    end else if (pick < 97) begin
      r.mode   = sccr_pkg::ModeFlush;
      r.sector = $urandom();
    end else begin
      r.mode   = ModeUnused;
      r.sector = $urandom();
    end
    return r;
  endfunction

  task automatic send_req(input sccr_pkg::req_t r);
    if (send_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_lookup(r);
  endtask

  task automatic test_directed();
    send_req(sccr_pkg::req_t'{sccr_pkg::ModeRead, 32'h0000_0000});   // miss on an invalid slot
    send_req(sccr_pkg::req_t'{sccr_pkg::ModeRead, 32'h0000_0000});   // hit
    send_req(sccr_pkg::req_t'{sccr_pkg::ModeWrite, 32'hFFFF_FFFF});  // write miss, no fetch
    send_req(sccr_pkg::req_t'{sccr_pkg::ModeWrite, 32'hFFFF_FFFF});
    send_req(sccr_pkg::req_t'{sccr_pkg::ModeRead, 32'hFFFF_FFFF});
    send_req(sccr_pkg::req_t'{sccr_pkg::ModeFlush, 32'h0000_0000});
    send_req(sccr_pkg::req_t'{sccr_pkg::ModeFlush, 32'hFFFF_FFFF});  // nothing dirty, no result
    send_req(sccr_pkg::req_t'{ModeUnused, 32'h1234_5678});           // dropped
    send_req(sccr_pkg::req_t'{sccr_pkg::ModeWrite, 32'h0000_0000});
    send_req(sccr_pkg::req_t'{sccr_pkg::ModeWrite, 32'h5555_5555});
    send_req(sccr_pkg::req_t'{sccr_pkg::ModeRead, 32'hAAAA_AAAA});
    send_req(sccr_pkg::req_t'{sccr_pkg::ModeFlush, 32'h5555_5555});
    send_req(sccr_pkg::req_t'{sccr_pkg::ModeRead, 32'hFFFF_FFFE});
    send_req(sccr_pkg::req_t'{ModeUnused, 32'hFFFF_FFFF});
  endtask

  // fill every slot dirty, then a flush returns a long burst
  task automatic test_full_flush();
    for (int k = 0; k < Entries; k++) send_req(sccr_pkg::req_t'{sccr_pkg::ModeWrite, $urandom()});
    send_req(sccr_pkg::req_t'{sccr_pkg::ModeFlush, $urandom()});
  endtask

  task automatic test_output_backpressure();
    send_idle_en     = 1'b0;
    long_hold_cycles = LongHold;
    for (int k = 0; k < 20; k++) send_req(rand_req());
    send_idle_en = 1'b1;
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    for (int unsigned k = 0; k < n_items; k++) begin
      if (k % 40 == 0) begin
        send_idle_en = ($urandom_range(0, 3) != 0);
        rsp_idle_en  = ($urandom_range(0, 3) != 0);
      end
      send_req(rand_req());
    end
  endtask

  task automatic test_full_rate(input int unsigned n_items);
    send_idle_en = 1'b0;
    rsp_idle_en  = 1'b0;
    for (int unsigned k = 0; k < n_items; k++) send_req(rand_req());
  endtask

  // result sink: random stall bursts, or one long counted hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_cycles != 0) begin
        out_ready <= 1'b0;
        for (int unsigned c = 1; c < long_hold_cycles; c++) @(posedge clk_i);
        long_hold_cycles = 0;
      end else if (rsp_idle_en && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void cmp_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %0h actual %0h", $time, name, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk_i) begin
    sccr_pkg::rsp_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %0h", $time, out_rsp_o);
        n_fail++;
      end else begin
        want = expected_rsp_q.pop_front();
        cmp_field("hit", 32'(want.hit), 32'(out_rsp_o.hit));
        cmp_field("slot", 32'(want.slot), 32'(out_rsp_o.slot));
        cmp_field("writeback", 32'(want.writeback), 32'(out_rsp_o.writeback));
        cmp_field("writeback_sector", want.writeback_sector, out_rsp_o.writeback_sector);
        cmp_field("fetch", 32'(want.fetch), 32'(out_rsp_o.fetch));
        cmp_field("last", 32'(want.last), 32'(out_rsp_o.last));
      end
    end
  end

  initial begin
    while (cycle_cnt < TimeoutCycles) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL sector_cache_clock_replacement");
    $finish;
  end

  initial begin
    for (int i = 0; i < Entries; i++) begin
      line_tag[i]   = '0;
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
      line_ref[i]   = 1'b0;
    end
    hand_pos = 0;
    for (int i = 0; i < HotSize; i++) hot_sector[i] = $urandom();
    hot_sector[0] = 32'h0000_0000;
    hot_sector[1] = 32'hFFFF_FFFF;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_flush();
    test_output_backpressure();
    test_random_traffic(300);
    test_full_rate(70);

    in_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("PASS sector_cache_clock_replacement");
    end else begin
      $display("FAIL sector_cache_clock_replacement");
    end
    $finish;
  end

endmodule
